[design/postfix_stack_evaluator_core_defines.svh]
// Assertion macros shared by the postfix evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define PSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("postfix evaluator assertion failed");
// next-cycle implication
`define PSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("postfix evaluator assertion failed");
`else
`define PSE_ASSERT_IMP(lbl, ante, cons)
`define PSE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/pse_pkg.sv]
// Types, opcodes and status codes of the postfix evaluator.
`default_nettype none
package pse_pkg;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  opcode_t;
  typedef logic [2:0]  status_t;

  localparam opcode_t OP_PUSH = 3'd0;
  localparam opcode_t OP_ADD  = 3'd1;
  localparam opcode_t OP_SUB  = 3'd2;
  localparam opcode_t OP_MUL  = 3'd3;
  localparam opcode_t OP_DIV  = 3'd4;
  localparam opcode_t OP_REM  = 3'd5;
  localparam opcode_t OP_END  = 3'd6;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_FEW      = 3'd2;
  localparam status_t ST_LEFTOVER = 3'd3;
  localparam status_t ST_DIVZERO  = 3'd4;
  localparam status_t ST_OVERFLOW = 3'd5;

  localparam int unsigned DIV_STEPS = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // absolute value as an unsigned word; the most negative value maps to itself
  function automatic word_t mag(word_t v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

[design/pse_stack_mem.sv]
// Operand stack storage: one write port, one registered read port.
`default_nettype none
module pse_stack_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire pse_pkg::word_t wdata,
  input  wire logic [AW-1:0] raddr,
  output pse_pkg::word_t     rdata
);
  import pse_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[design/pse_div.sv]
// Radix-2 restoring divider on unsigned 32-bit magnitudes, one bit a cycle.
`default_nettype none
module pse_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire pse_pkg::word_t  dividend,
  input  wire pse_pkg::word_t  divisor,
  output pse_pkg::div_stat_t   stat,
  output pse_pkg::word_t       quotient,
  output pse_pkg::word_t       remainder
);
  import pse_pkg::*;

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  word_t         rem_r, rem_nxt;
  word_t         quo_r, quo_nxt;
  word_t         dvs_r, dvs_nxt;
  logic [32:0]   shifted;
  logic [32:0]   diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt = CW'(DIV_STEPS);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      // subtract when the shifted partial remainder covers the divisor
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[design/postfix_stack_evaluator_core.sv]
// Postfix expression evaluator: operand stack in memory, top of stack in a register.
// Tokens enter on the in_ channel, opcode in in_tuser and push value in in_tdata.
// Push, end and ignored tokens, and operators that raise an error, finish in the accepting cycle;
// add, subtract and multiply then pass through a read state, since the left operand comes out
// of the registered read port of the stack memory while the right operand sits in the
// top-of-stack register. Divide and remainder go through the accepting cycle, the
// memory read, the 32 steps of the bit-serial divider and one writeback.
// An end token emits one beat on the out_ channel (value in out_tdata, status in
// out_tuser) into an output register; it is taken while that register is empty or
// draining, and other tokens are taken while a result still waits.
`default_nettype none
`include "postfix_stack_evaluator_core_defines.svh"
module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] operand
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] result
  output logic [2:0]       out_tuser   // [2:0] status
);
  import pse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  status_t       err_r, err_nxt;
  word_t         tos_r, tos_nxt;
  opcode_t       op_r, op_nxt;
  logic          neg_q_r, neg_q_nxt;
  logic          neg_l_r, neg_l_nxt;
  logic          out_valid_r, out_valid_nxt;
  word_t         out_result_r, out_result_nxt;
  status_t       out_status_r, out_status_nxt;

  logic          in_acc;
  opcode_t       opcode;
  logic [DW-1:0] dm1, dm2;
  logic          mem_we;
  word_t         left;
  word_t         prod;
  logic          div_start;
  div_stat_t     div_stat;
  word_t         div_q, div_r;

  assign opcode = in_tuser;
  assign in_acc = in_tvalid && in_tready;
  assign dm1    = depth_r - DW'(1);
  assign dm2    = depth_r - DW'(2);

  // end tokens need the output register; everything else only needs an idle sequencer
  assign in_tready = (state_r == S_IDLE) &&
                     ((opcode != OP_END) || !out_valid_r || out_tready);

  // push spills the old top into memory; reads and writes never target one entry
  // in the same cycle since the write address is depth-1 and the read address depth-2
  assign mem_we = in_acc && (opcode == OP_PUSH) && (err_r == ST_OK) &&
                  (depth_r != DW'(STACK_DEPTH)) && (depth_r != '0);

  pse_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (dm1[AW-1:0]),
    .wdata (tos_r),
    .raddr (dm2[AW-1:0]),
    .rdata (left)
  );

  assign prod      = word_t'(left * tos_r);
  assign div_start = (state_r == S_RD) && ((op_r == OP_DIV) || (op_r == OP_REM));

  pse_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag(left)),
    .divisor   (mag(tos_r)),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    err_nxt        = err_r;
    tos_nxt        = tos_r;
    op_nxt         = op_r;
    neg_q_nxt      = neg_q_r;
    neg_l_nxt      = neg_l_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_result_nxt = out_result_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (opcode == OP_END) begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = '0;
            if (err_r != ST_OK) begin
              out_status_nxt = err_r;
            end else if (depth_r == '0) begin
              out_status_nxt = ST_EMPTY;
            end else if (depth_r != DW'(1)) begin
              out_status_nxt = ST_LEFTOVER;
            end else begin
              out_status_nxt = ST_OK;
              out_result_nxt = tos_r;
            end
            depth_nxt = '0;
            err_nxt   = ST_OK;
          end else if (err_r != ST_OK) begin
            // drop tokens until the next end
          end else if (opcode == OP_PUSH) begin
            if (depth_r == DW'(STACK_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              tos_nxt   = in_tdata;
              depth_nxt = depth_r + DW'(1);
            end
          end else if (opcode inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM}) begin
            if (depth_r < DW'(2)) begin
              err_nxt = ST_FEW;
            end else if ((opcode == OP_DIV || opcode == OP_REM) && tos_r == '0) begin
              err_nxt = ST_DIVZERO;
            end else begin
              op_nxt    = opcode;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        case (op_r)
          OP_ADD: tos_nxt = left + tos_r;
          OP_SUB: tos_nxt = left - tos_r;
          OP_MUL: tos_nxt = prod;
          default: ;
        endcase
        if (div_start) begin
          neg_q_nxt = left[31] ^ tos_r[31];
          neg_l_nxt = left[31];
          state_nxt = S_DIV;
        end else begin
          depth_nxt = dm1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (op_r == OP_DIV) begin
            tos_nxt = neg_q_r ? (32'd0 - div_q) : div_q;
          end else begin
            tos_nxt = neg_l_r ? (32'd0 - div_r) : div_r;
          end
          depth_nxt = dm1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    op_r         <= op_nxt;
    neg_q_r      <= neg_q_nxt;
    neg_l_r      <= neg_l_nxt;
    out_result_r <= out_result_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_result_r;
  assign out_tuser  = out_status_r;

  `PSE_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= DW'(STACK_DEPTH))
  `PSE_ASSERT_IMP(a_done_in_div, div_stat.done, state_r == S_DIV)
  `PSE_ASSERT_IMP(a_div_live, state_r == S_DIV, div_stat.busy || div_stat.done)
  `PSE_ASSERT_IMP(a_err_zero, out_valid_r && out_status_r != ST_OK, out_result_r == '0)
  `PSE_ASSERT_NXT(a_end_clears, in_acc && opcode == OP_END, depth_r == '0 && err_r == ST_OK)

endmodule
`default_nettype wire
